/* hdl/kla_pkg.sv */
package kla_pkg;

    localparam int ID_W      = 10;
    localparam int STEPS_W   = 16;
    localparam int MAX_NODES = 1 << ID_W;
    localparam int LEVELS    = 10;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int ADDR_W    = LVL_W + ID_W;
    localparam int DEPTH     = LEVELS * MAX_NODES;

    localparam logic [ID_W-1:0] NODE_COUNT_RST = ID_W'(MAX_NODES - 1);
    localparam logic [ID_W-1:0] LAST_NODE      = ID_W'(MAX_NODES - 1);
    localparam logic [LVL_W-1:0] LAST_LEVEL    = LVL_W'(LEVELS - 1);

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type             req_type;
        logic [ID_W-1:0]       node;
        logic [ID_W-1:0]       boss;
        logic [STEPS_W-1:0]    steps;
    } t_req;

    typedef struct packed {
        logic                  found;
        logic [ID_W-1:0]       ancestor;
    } t_res;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [ID_W-1:0]       wdata;
        logic [ADDR_W-1:0]     raddr_a;
        logic [ADDR_W-1:0]     raddr_b;
    } t_mem_req;

    typedef struct packed {
        logic [ID_W-1:0]       rdata_a;
        logic [ID_W-1:0]       rdata_b;
    } t_mem_rsp;

    function automatic logic f_valid(input logic [ID_W-1:0] id,
                                     input logic [ID_W-1:0] count);
        return (id != '0) && (id <= count);
    endfunction

endpackage

/* hdl/kla_if.sv */
interface kla_req_if
    import kla_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [ID_W-1:0]    node;
    logic [ID_W-1:0]    boss;
    logic [STEPS_W-1:0] steps;

    modport source (output valid, req_type, node, boss, steps, input ready);
    modport sink   (input valid, req_type, node, boss, steps, output ready);
endinterface

interface kla_rsp_if
    import kla_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               found;
    logic [ID_W-1:0]    ancestor;

    modport source (output valid, found, ancestor, input ready);
    modport sink   (input valid, found, ancestor, output ready);
endinterface

/* hdl/kth_ancestor_binary_lifting.sv */
// channel   dir  handshake      payload
// i_req     in   valid/ready    req_type, node, boss, steps
// o_rsp     out  valid/ready    found, ancestor
// cfg       in   i_cfg_we       i_cfg_wdata (node_count)
//
// Reset clears level 0 of the jump table, one entry a cycle, i_req held off.
// Load beat: one table write, skipped when node is out of range.
// Query beat: one table read per set step bit (S_WALK issues it, S_LOOK takes the result).
// First query after reset, a cfg write or a load that wrote first rebuilds levels 1..LEVELS-1,
// one entry a cycle in S_BUILD over two read ports, with S_DRAIN between levels.
// Output register lets a result wait on o_rsp while the next beat is taken.
module kth_ancestor_binary_lifting
    import kla_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [ID_W-1:0] i_cfg_wdata,
    kla_req_if.sink         i_req,
    kla_rsp_if.source       o_rsp
);

    logic [ID_W-1:0] r_node_count;
    logic            r_out_valid;
    t_res            r_out;

    t_req            w_req;
    logic            w_ready;
    logic            w_res_valid;
    t_res            w_res;
    logic            w_res_ready;
    t_mem_req        w_mem_req;
    t_mem_rsp        w_mem_rsp;

    assign w_req.req_type = t_req_type'(i_req.req_type);
    assign w_req.node     = i_req.node;
    assign w_req.boss     = i_req.boss;
    assign w_req.steps    = i_req.steps;
    assign i_req.ready    = w_ready;

    assign w_res_ready    = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.found    = r_out.found;
    assign o_rsp.ancestor = r_out.ancestor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (w_res_ready) begin
                r_out_valid <= w_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    kla_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_req.valid),
        .o_ready      (w_ready),
        .i_req        (w_req),
        .i_cfg_we     (i_cfg_we),
        .i_node_count (r_node_count),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_ready  (w_res_ready),
        .o_mem        (w_mem_req),
        .i_mem        (w_mem_rsp)
    );

    kla_table u_table (
        .i_clk (i_clk),
        .i_mem (w_mem_req),
        .o_mem (w_mem_rsp)
    );

    a_found_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.found == (r_out.ancestor != '0)))
        else $error("found flag disagrees with ancestor");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(r_out)))
        else $error("result beat changed while stalled");

    a_ready_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ready && w_res_valid))
        else $error("request ready while a result is pending");

endmodule

/* hdl/kla_table.sv */
module kla_table
    import kla_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_mem,
    output t_mem_rsp o_mem
);

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rdata_a;
    logic [ID_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
        r_rdata_a <= r_mem[i_mem.raddr_a];
        r_rdata_b <= r_mem[i_mem.raddr_b];
    end

    assign o_mem.rdata_a = r_rdata_a;
    assign o_mem.rdata_b = r_rdata_b;

endmodule

/* hdl/kla_seq.sv */
module kla_seq
    import kla_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_req            i_req,
    input  logic            i_cfg_we,
    input  logic [ID_W-1:0] i_node_count,
    output logic            o_res_valid,
    output t_res            o_res,
    input  logic            i_res_ready,
    output t_mem_req        o_mem,
    input  t_mem_rsp        i_mem
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_BUILD = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_WALK  = 7'b0010000,
        S_LOOK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [ID_W-1:0]    r_cnt, n_cnt;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic [ID_W-1:0]    r_cur, n_cur;
    logic [LEVELS-1:0]  r_steps, n_steps;
    logic               r_stale, n_stale;
    logic               r_p1_valid, n_p1_valid;
    logic [ID_W-1:0]    r_p1_v, n_p1_v;
    logic               r_p1_ok, n_p1_ok;
    logic               r_p2_valid, n_p2_valid;
    logic [ID_W-1:0]    r_p2_v, n_p2_v;
    logic               r_p2_ok, n_p2_ok;

    logic [LVL_W-1:0]   w_prev_lvl;
    logic [ID_W-1:0]    w_mid;

    assign w_prev_lvl  = r_lvl - LVL_W'(1);
    assign w_mid       = r_p1_ok ? i_mem.rdata_a : '0;
    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.found    = (r_cur != '0);
    assign o_res.ancestor = r_cur;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_lvl      = r_lvl;
        n_cur      = r_cur;
        n_steps    = r_steps;
        n_stale    = r_stale;
        n_p1_valid = 1'b0;
        n_p1_v     = r_p1_v;
        n_p1_ok    = r_p1_ok;
        n_p2_valid = r_p1_valid;
        n_p2_v     = r_p1_v;
        n_p2_ok    = f_valid(w_mid, i_node_count);

        o_mem         = '0;
        o_mem.raddr_b = {w_prev_lvl, w_mid};
        if (r_p2_valid) begin
            o_mem.we    = 1'b1;
            o_mem.waddr = {r_lvl, r_p2_v};
            o_mem.wdata = r_p2_ok ? i_mem.rdata_b : '0;
        end

        case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = {{LVL_W{1'b0}}, r_cnt};
                o_mem.wdata = '0;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == LAST_NODE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_req.req_type == REQ_LOAD) begin
                        if (f_valid(i_req.node, i_node_count)) begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = {{LVL_W{1'b0}}, i_req.node};
                            o_mem.wdata = i_req.boss;
                            n_stale     = 1'b1;
                        end
                    end else begin
                        n_cur   = (f_valid(i_req.node, i_node_count) &&
                                   (i_req.steps[STEPS_W-1:LEVELS] == '0)) ?
                                  i_req.node : '0;
                        n_steps = i_req.steps[LEVELS-1:0];
                        n_cnt   = '0;
                        if (r_stale) begin
                            n_lvl   = LVL_W'(1);
                            n_state = S_BUILD;
                        end else begin
                            n_lvl   = '0;
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_BUILD: begin
                o_mem.raddr_a = {w_prev_lvl, r_cnt};
                n_p1_valid    = 1'b1;
                n_p1_v        = r_cnt;
                n_p1_ok       = f_valid(r_cnt, i_node_count);
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == LAST_NODE) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1_valid && !r_p2_valid) begin
                    if (r_lvl == LAST_LEVEL) begin
                        n_stale = 1'b0;
                        n_lvl   = '0;
                        n_state = S_WALK;
                    end else begin
                        n_lvl   = r_lvl + LVL_W'(1);
                        n_cnt   = '0;
                        n_state = S_BUILD;
                    end
                end
            end
            S_WALK: begin
                if ((r_cur == '0) || (r_steps == '0)) begin
                    n_state = S_DONE;
                end else if (r_steps[0]) begin
                    o_mem.raddr_a = {r_lvl, r_cur};
                    n_state       = S_LOOK;
                end else begin
                    n_steps = r_steps >> 1;
                    n_lvl   = r_lvl + LVL_W'(1);
                end
            end
            S_LOOK: begin
                n_cur   = f_valid(i_mem.rdata_a, i_node_count) ? i_mem.rdata_a : '0;
                n_steps = r_steps >> 1;
                n_lvl   = r_lvl + LVL_W'(1);
                n_state = S_WALK;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_stale = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_stale    <= 1'b1;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_stale    <= n_stale;
            r_p1_valid <= n_p1_valid;
            r_p2_valid <= n_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl   <= n_lvl;
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_p1_v  <= n_p1_v;
        r_p1_ok <= n_p1_ok;
        r_p2_v  <= n_p2_v;
        r_p2_ok <= n_p2_ok;
    end

    a_walk_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_LOOK) |-> !o_mem.we)
        else $error("table written during walk");

    a_stale_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_stale) |-> $past(r_state == S_DRAIN))
        else $error("table marked fresh outside rebuild");

    a_build_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_valid |-> (o_mem.we && (r_lvl != '0)))
        else $error("rebuild write lost or aimed at level zero");

endmodule
